// File: rtl/ssr_pkg.sv
// shared constants, register codes and control structs for the stream search/replace unit
// no dependencies; used by every other rtl file
`default_nettype none

package ssr_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACE_MAX_DEF = 8;
   localparam int COUNT_BITS_DEF  = 16;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 4;
   localparam int OCC_W       = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES     = 3'd0,
      CSR_PATTERN_LEN       = 3'd1,
      CSR_REPLACEMENT_BYTES = 3'd2,
      CSR_REPLACEMENT_LEN   = 3'd3,
      CSR_FIRST_OCCURRENCE  = 3'd4,
      CSR_LIMIT_ENABLE      = 3'd5,
      CSR_MAX_REPLACEMENTS  = 3'd6
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] PATTERN_BYTES_RST     = '0;
   localparam logic [LEN_W-1:0]      PATTERN_LEN_RST       = 4'd1;
   localparam logic [CSR_DATA_W-1:0] REPLACEMENT_BYTES_RST = '0;
   localparam logic [LEN_W-1:0]      REPLACEMENT_LEN_RST   = 4'd0;
   localparam logic [OCC_W-1:0]      FIRST_OCCURRENCE_RST  = 16'd1;
   localparam logic                  LIMIT_ENABLE_RST      = 1'b0;
   localparam logic [OCC_W-1:0]      MAX_REPLACEMENTS_RST  = 16'd0;

   typedef struct packed {
      logic load_item;
      logic step;
      logic emit;
      logic csr_write;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
      logic nothing;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/ssr_if.sv
// request, response and register-write channel interfaces
// depends on ssr_pkg
`default_nettype none

interface ssr_req_if;
   logic                          valid;
   logic                          ready;
   logic [ssr_pkg::BYTE_W-1:0]    text_byte;
   logic                          byte_valid;
   logic                          text_end;

   modport source (output valid, output text_byte, output byte_valid, output text_end,
                   input ready);
   modport sink   (input valid, input text_byte, input byte_valid, input text_end,
                   output ready);
endinterface

interface ssr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssr_pkg::BYTE_W-1:0]    out_byte;
   logic                          out_valid;
   logic                          out_end;

   modport source (output valid, output out_byte, output out_valid, output out_end,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_end,
                   output ready);
endinterface

interface ssr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ssr_pkg::CSR_INDEX_W-1:0]   index;
   logic [ssr_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ssr_ctrl.sv
// controller fsm: sequences register writes, request load, the step and the result bytes
// depends on ssr_pkg
`default_nettype none

module ssr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   csr_valid,
   input  wire ssr_pkg::dp_status_type status,
   output ssr_pkg::ctl_cmd_type        cmd,
   output logic                        req_ready,
   output logic                        csr_ready
);

   typedef enum logic [1:0] {
      IDLE,
      STEP,
      EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         IDLE: begin
            csr_ready     = 1'b1;
            req_ready     = !csr_valid;
            cmd.csr_write = csr_valid;
            if (req_valid && !csr_valid) begin
               cmd.load_item = 1'b1;
               state_in      = STEP;
            end
         end
         STEP: begin
            cmd.step = 1'b1;
            state_in = EMIT;
         end
         EMIT: begin
            if (status.nothing) begin
               state_in = IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register busy");

   a_req_then_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == STEP))
      else $error("accepted request not followed by step cycle");

   a_no_csr_with_req: assert property (@(posedge clock) disable iff (reset)
      !(cmd.csr_write && cmd.load_item))
      else $error("register write and request load in the same cycle");

endmodule

`default_nettype wire

// File: rtl/ssr_datapath.sv
// datapath: config registers, match window, counters, result buffer, output register
// depends on ssr_pkg
`default_nettype none

module ssr_datapath #(
   parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF,
   parameter int COUNT_BITS  = ssr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ssr_pkg::ctl_cmd_type               cmd,
   output ssr_pkg::dp_status_type                  status,
   input  wire logic [ssr_pkg::BYTE_W-1:0]         req_text_byte,
   input  wire logic                               req_byte_valid,
   input  wire logic                               req_text_end,
   input  wire logic [ssr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ssr_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic [ssr_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                    rsp_out_valid,
   output logic                                    rsp_out_end
);

   localparam int LEN_W     = ssr_pkg::LEN_W;
   localparam int BW        = ssr_pkg::BYTE_W;
   localparam int FILL_W    = $clog2(PATTERN_MAX + 1);
   localparam int SEQ_MAX   = (REPLACE_MAX > PATTERN_MAX) ? REPLACE_MAX : PATTERN_MAX;
   localparam int SEQ_W     = $clog2(SEQ_MAX + 1);
   localparam int BUF_DEPTH = (REPLACE_MAX > 0) ? REPLACE_MAX : 1;
   localparam int CMP_W     = (COUNT_BITS > ssr_pkg::OCC_W) ? COUNT_BITS : ssr_pkg::OCC_W;

   // configuration registers
   logic [ssr_pkg::CSR_DATA_W-1:0] pattern_ff;
   logic [LEN_W-1:0]               plen_reg_ff;
   logic [ssr_pkg::CSR_DATA_W-1:0] repl_ff;
   logic [LEN_W-1:0]               rlen_reg_ff;
   logic [ssr_pkg::OCC_W-1:0]      first_occ_ff;
   logic                           limit_en_ff;
   logic [ssr_pkg::OCC_W-1:0]      max_rep_ff;

   // text state
   logic [BW-1:0]          win_ff [PATTERN_MAX];
   logic [BW-1:0]          win_in [PATTERN_MAX];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [COUNT_BITS-1:0]  occ_ff, occ_in;
   logic [COUNT_BITS-1:0]  rep_ff, rep_in;

   // current request
   logic [BW-1:0]          item_byte_ff;
   logic                   item_valid_ff;
   logic                   item_end_ff;

   // pending results: buffer bytes first, then flushed window bytes
   logic [BW-1:0]          buf_ff [BUF_DEPTH];
   logic [BW-1:0]          buf_in [BUF_DEPTH];
   logic [SEQ_W-1:0]       bcnt_ff, bcnt_in;
   logic [SEQ_W-1:0]       total_ff, total_in;
   logic [SEQ_W-1:0]       idx_ff;
   logic [SEQ_W-1:0]       flush_cnt;
   logic [SEQ_W-1:0]       rel_idx;

   logic                   rsp_valid_ff;
   logic [BW-1:0]          rsp_byte_ff;
   logic                   rsp_bvalid_ff;
   logic                   rsp_end_ff;

   logic [LEN_W-1:0]       plen;
   logic [LEN_W-1:0]       rlen;
   logic                   hit;
   logic                   last;
   logic [BW-1:0]          seq_byte;

   always_comb begin
      if (plen_reg_ff == '0) begin
         plen = LEN_W'(1);
      end else if (plen_reg_ff > LEN_W'(PATTERN_MAX)) begin
         plen = LEN_W'(PATTERN_MAX);
      end else begin
         plen = plen_reg_ff;
      end
      if (rlen_reg_ff > LEN_W'(REPLACE_MAX)) begin
         rlen = LEN_W'(REPLACE_MAX);
      end else begin
         rlen = rlen_reg_ff;
      end
   end

   // one request applied to the window and counters
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      occ_in  = occ_ff;
      rep_in  = rep_ff;
      buf_in  = buf_ff;
      bcnt_in = '0;
      hit     = 1'b0;
      if (item_valid_ff) begin
         if (first_occ_ff == '0) begin
            // no searching: keep the last pattern-length bytes
            if (LEN_W'(fill_in) >= plen) begin
               for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                  win_in[k] = win_in[k+1];
               end
               win_in[PATTERN_MAX-1] = '0;
               fill_in = fill_in - 1'b1;
            end
            for (int k = 0; k < PATTERN_MAX; k++) begin
               if (fill_in == FILL_W'(k)) begin
                  win_in[k] = item_byte_ff;
               end
            end
            fill_in = fill_in + 1'b1;
         end else begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
               if (fill_in == FILL_W'(k)) begin
                  win_in[k] = item_byte_ff;
               end
            end
            fill_in = fill_in + 1'b1;
            if (LEN_W'(fill_in) >= plen) begin
               hit = !(limit_en_ff && (CMP_W'(rep_ff) >= CMP_W'(max_rep_ff)));
               for (int k = 0; k < PATTERN_MAX; k++) begin
                  if ((LEN_W'(k) < plen) && (win_in[k] != pattern_ff[BW*k +: BW])) begin
                     hit = 1'b0;
                  end
               end
               if (hit && (occ_in != {COUNT_BITS{1'b1}})) begin
                  occ_in = occ_in + 1'b1;
               end
               if (hit && (CMP_W'(occ_in) >= CMP_W'(first_occ_ff))) begin
                  for (int k = 0; k < BUF_DEPTH; k++) begin
                     buf_in[k] = repl_ff[BW*k +: BW];
                  end
                  bcnt_in = SEQ_W'(rlen);
                  if (rep_in != {COUNT_BITS{1'b1}}) begin
                     rep_in = rep_in + 1'b1;
                  end
                  fill_in = '0;
               end else begin
                  // no replacement: only the head byte leaves the window
                  buf_in[0] = win_in[0];
                  bcnt_in   = SEQ_W'(1);
                  for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                     win_in[k] = win_in[k+1];
                  end
                  win_in[PATTERN_MAX-1] = '0;
                  fill_in = fill_in - 1'b1;
               end
            end
         end
      end
      if (item_end_ff && ((first_occ_ff != '0) || (LEN_W'(fill_in) < plen))) begin
         flush_cnt = SEQ_W'(fill_in);
      end else begin
         flush_cnt = '0;
      end
      total_in = bcnt_in + flush_cnt;
   end

   // next result byte
   always_comb begin
      last     = (total_ff == '0) || (idx_ff == (total_ff - SEQ_W'(1)));
      rel_idx  = idx_ff - bcnt_ff;
      seq_byte = '0;
      if (idx_ff < bcnt_ff) begin
         for (int k = 0; k < BUF_DEPTH; k++) begin
            if (idx_ff == SEQ_W'(k)) begin
               seq_byte = buf_ff[k];
            end
         end
      end else begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            if (rel_idx == SEQ_W'(k)) begin
               seq_byte = win_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= ssr_pkg::PATTERN_BYTES_RST;
         plen_reg_ff  <= ssr_pkg::PATTERN_LEN_RST;
         repl_ff      <= ssr_pkg::REPLACEMENT_BYTES_RST;
         rlen_reg_ff  <= ssr_pkg::REPLACEMENT_LEN_RST;
         first_occ_ff <= ssr_pkg::FIRST_OCCURRENCE_RST;
         limit_en_ff  <= ssr_pkg::LIMIT_ENABLE_RST;
         max_rep_ff   <= ssr_pkg::MAX_REPLACEMENTS_RST;
         fill_ff      <= '0;
         occ_ff       <= '0;
         rep_ff       <= '0;
         bcnt_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.csr_write) begin
            case (ssr_pkg::csr_index_type'(csr_index))
               ssr_pkg::CSR_PATTERN_BYTES:     pattern_ff   <= csr_data;
               ssr_pkg::CSR_PATTERN_LEN:       plen_reg_ff  <= csr_data[LEN_W-1:0];
               ssr_pkg::CSR_REPLACEMENT_BYTES: repl_ff      <= csr_data;
               ssr_pkg::CSR_REPLACEMENT_LEN:   rlen_reg_ff  <= csr_data[LEN_W-1:0];
               ssr_pkg::CSR_FIRST_OCCURRENCE:  first_occ_ff <= csr_data[ssr_pkg::OCC_W-1:0];
               ssr_pkg::CSR_LIMIT_ENABLE:      limit_en_ff  <= csr_data[0];
               ssr_pkg::CSR_MAX_REPLACEMENTS:  max_rep_ff   <= csr_data[ssr_pkg::OCC_W-1:0];
               default: begin
               end
            endcase
            // any write drops the text in progress
            fill_ff <= '0;
            occ_ff  <= '0;
            rep_ff  <= '0;
         end
         if (cmd.step) begin
            fill_ff  <= fill_in;
            occ_ff   <= occ_in;
            rep_ff   <= rep_in;
            bcnt_ff  <= bcnt_in;
            total_ff <= total_in;
            idx_ff   <= '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_ff + 1'b1;
            if (last && item_end_ff) begin
               fill_ff <= '0;
               occ_ff  <= '0;
               rep_ff  <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_byte_ff  <= req_text_byte;
         item_valid_ff <= req_byte_valid;
         item_end_ff   <= req_text_end;
      end
      if (cmd.step) begin
         win_ff <= win_in;
         buf_ff <= buf_in;
      end
      if (cmd.emit) begin
         // a bare end marker carries a zero byte
         rsp_byte_ff   <= (total_ff != '0) ? seq_byte : '0;
         rsp_bvalid_ff <= (total_ff != '0);
         rsp_end_ff    <= item_end_ff && last;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.last     = last;
   assign status.nothing  = (total_ff == '0) && !item_end_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_valid = rsp_bvalid_ff;
   assign rsp_out_end   = rsp_end_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (idx_ff < total_ff) || (total_ff == '0))
      else $error("result index past pending count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && last && item_end_ff) |=> (fill_ff == '0) && (occ_ff == '0) && (rep_ff == '0))
      else $error("text state not cleared after last result");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.csr_write |=> (fill_ff == '0) && (occ_ff == '0) && (rep_ff == '0))
      else $error("text state not cleared after register write");

endmodule

`default_nettype wire

// File: rtl/stream_search_replace_unit.sv
// a request is taken in IDLE and applied in STEP, where the window and counters are
// registered; its first result is loaded into the output register in EMIT, and later results
// follow one per cycle while the output is not stalled. no new request is taken until all
// n results of the last one are sent, n being its result count (at most 8 by default).
// reset: config registers take their default values and the fill count and counters clear
// at once, with no clearing pass; the window bytes themselves are not reset.
// depends on ssr_pkg, ssr_if, ssr_ctrl and ssr_datapath
`default_nettype none

module stream_search_replace_unit #(
   parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF,
   parameter int COUNT_BITS  = ssr_pkg::COUNT_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ssr_req_if.sink   req_ch,
   ssr_rsp_if.source rsp_ch,
   ssr_csr_if.sink   csr_ch
);

   ssr_pkg::ctl_cmd_type   cmd;
   ssr_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   csr_ready;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .csr_valid (csr_ch.valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready),
      .csr_ready (csr_ready)
   );

   ssr_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_text_byte  (req_ch.text_byte),
      .req_byte_valid (req_ch.byte_valid),
      .req_text_end   (req_ch.text_end),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_out_byte   (rsp_ch.out_byte),
      .rsp_out_valid  (rsp_ch.out_valid),
      .rsp_out_end    (rsp_ch.out_end)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = csr_ready;

endmodule

`default_nettype wire
